// ===== rtl/lsg_pkg.sv =====
// Shared constants, types and the arctangent table of the segment geometry unit.
package lsg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CS_N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    localparam int DELTA_W = 28;
    localparam int SQ_W    = 54;
    localparam int SUM_W   = 55;
    localparam int ROOT_W  = 28;
    localparam int REM_W   = 56;
    localparam int ROT_W   = 34;

    localparam int LEN_LAT  = ROOT_W + 3;
    localparam int ANG_LAT  = 2 * CS_N + 3;
    localparam int BACK_LAT = (LEN_LAT > ANG_LAT) ? LEN_LAT : ANG_LAT;

    localparam int FRONT_LAT   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [31:0]             HALF_TURN = 32'h8000_0000;
    localparam logic signed [ROT_W-1:0] GAIN_Q30  = 34'sd652032874;
    localparam logic signed [15:0]      Q14_ONE   = 16'sd16384;

    localparam logic REG_OFFSET_X = 1'b0;
    localparam logic REG_OFFSET_Y = 1'b1;

    typedef logic signed [31:0]        mm_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        mm_t    from_x;
        mm_t    from_y;
        mm_t    to_x;
        mm_t    to_y;
        delta_t dx;
        delta_t dy;
    } seg_t;

    function automatic logic [31:0] atan_q32(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lsg_front.sv =====
// Front pipeline: offset removal, metre to millimetre scaling with rounding, deltas.
module lsg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_start_east,
    input  logic signed [31:0] s_start_north,
    input  logic signed [31:0] s_end_east,
    input  logic signed [31:0] s_end_north,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    output logic               out_valid,
    input  logic               out_ready,
    output lsg_pkg::seg_t      out_item
);

    logic [lsg_pkg::FRONT_LAT-1:0] vld_reg;
    logic                          en;

    logic signed [31:0] coord [4];
    logic signed [31:0] offs  [4];

    logic signed [32:0] diff_next [4];
    logic signed [32:0] diff_reg  [4];
    logic        [42:0] mag_next  [4];
    logic        [42:0] mag_reg   [4];
    logic               neg_next  [4];
    logic               neg_reg   [4];
    lsg_pkg::mm_t       mm_next   [4];
    lsg_pkg::mm_t       mm_reg    [4];
    lsg_pkg::seg_t      item_next;
    lsg_pkg::seg_t      item_reg;

    assign en        = !vld_reg[lsg_pkg::FRONT_LAT-1] || out_ready;
    assign s_ready   = en;
    assign out_valid = vld_reg[lsg_pkg::FRONT_LAT-1];
    assign out_item  = item_reg;

    assign coord[0] = s_start_north;
    assign coord[1] = s_start_east;
    assign coord[2] = s_end_north;
    assign coord[3] = s_end_east;
    assign offs[0]  = offset_x;
    assign offs[1]  = offset_y;
    assign offs[2]  = offset_x;
    assign offs[3]  = offset_y;

    always_comb begin
        logic signed [42:0] d;
        logic signed [42:0] p;
        logic        [42:0] r;
        for (int k = 0; k < 4; k++) begin
            diff_next[k] = 33'(coord[k]) - 33'(offs[k]);
            d = 43'(diff_reg[k]);
            p = (d <<< 10) - (d <<< 4) - (d <<< 3);
            neg_next[k] = p[42];
            mag_next[k] = p[42] ? 43'(-p) : 43'(p);
            r = mag_reg[k] + 43'd32768;
            mm_next[k] = neg_reg[k] ? -32'(r[42:16]) : 32'(r[42:16]);
        end
        item_next.from_x = mm_reg[0];
        item_next.from_y = mm_reg[1];
        item_next.to_x   = mm_reg[2];
        item_next.to_y   = mm_reg[3];
        item_next.dx     = lsg_pkg::DELTA_W'(mm_reg[2] - mm_reg[0]);
        item_next.dy     = lsg_pkg::DELTA_W'(mm_reg[3] - mm_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[lsg_pkg::FRONT_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                diff_reg[k] <= diff_next[k];
                mag_reg[k]  <= mag_next[k];
                neg_reg[k]  <= neg_next[k];
                mm_reg[k]   <= mm_next[k];
            end
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/lsg_queue.sv =====
// Short queue that decouples the front pipeline from the back pipeline.
module lsg_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lsg_pkg::seg_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output lsg_pkg::seg_t out_item
);

    lsg_pkg::seg_t                mem_reg [lsg_pkg::QUEUE_DEPTH];
    logic [lsg_pkg::QUEUE_AW-1:0] wr_reg, wr_next;
    logic [lsg_pkg::QUEUE_AW-1:0] rd_reg, rd_next;
    logic [lsg_pkg::QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                         push, pop;

    assign in_ready  = cnt_reg != (lsg_pkg::QUEUE_AW + 1)'(lsg_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (lsg_pkg::QUEUE_AW + 1)'(push) - (lsg_pkg::QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/lsg_back.sv =====
// Back pipeline: length by square root, heading by vectoring CORDIC, sine and cosine.
module lsg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsg_pkg::seg_t      in_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_from_x_mm,
    output logic signed [31:0] m_from_y_mm,
    output logic signed [31:0] m_to_x_mm,
    output logic signed [31:0] m_to_y_mm,
    output logic        [31:0] m_length_mm,
    output logic signed [15:0] m_heading,
    output logic signed [15:0] m_heading_sin,
    output logic signed [15:0] m_heading_cos
);

    localparam int N    = lsg_pkg::CS_N;
    localparam int L    = lsg_pkg::BACK_LAT;
    localparam int RW   = lsg_pkg::ROOT_W;
    localparam int EW   = lsg_pkg::REM_W;
    localparam int ZW   = lsg_pkg::ROT_W;
    localparam int LPAD = L - lsg_pkg::LEN_LAT;
    localparam int APAD = L - lsg_pkg::ANG_LAT;

    logic [L-1:0] vld_reg;
    logic         en;

    assign en       = !vld_reg[L-1] || m_ready;
    assign in_ready = en;
    assign m_valid  = vld_reg[L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    // coordinates ride along
    logic [127:0] crd_reg [L];
    always_ff @(posedge aclk) begin
        if (en) begin
            crd_reg[0] <= {in_item.from_x, in_item.from_y, in_item.to_x, in_item.to_y};
            for (int k = 1; k < L; k++) begin
                crd_reg[k] <= crd_reg[k-1];
            end
        end
    end
    assign m_from_x_mm = crd_reg[L-1][127:96];
    assign m_from_y_mm = crd_reg[L-1][95:64];
    assign m_to_x_mm   = crd_reg[L-1][63:32];
    assign m_to_y_mm   = crd_reg[L-1][31:0];

    // length
    logic [26:0]                ax, ay;
    logic [lsg_pkg::SQ_W-1:0]   sqa_reg, sqb_reg;
    logic [lsg_pkg::SUM_W-1:0]  sum_reg;
    logic [EW-1:0]              rem_reg  [RW];
    logic [RW-1:0]              root_reg [RW];
    logic [31:0]                len_reg;
    logic [31:0]                len_out;

    assign ax = in_item.dx[lsg_pkg::DELTA_W-1] ? 27'(-in_item.dx) : 27'(in_item.dx);
    assign ay = in_item.dy[lsg_pkg::DELTA_W-1] ? 27'(-in_item.dy) : 27'(in_item.dy);

    always_ff @(posedge aclk) begin
        if (en) begin
            sqa_reg <= lsg_pkg::SQ_W'(ax) * lsg_pkg::SQ_W'(ax);
            sqb_reg <= lsg_pkg::SQ_W'(ay) * lsg_pkg::SQ_W'(ay);
            sum_reg <= lsg_pkg::SUM_W'(sqa_reg) + lsg_pkg::SUM_W'(sqb_reg);
            len_reg <= 32'(root_reg[RW-1]) + 32'(EW'(rem_reg[RW-1]) > EW'(root_reg[RW-1]));
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [EW-1:0] rem_prev;
        logic [RW-1:0] root_prev;
        logic [EW-1:0] trial;
        if (j == 0) begin : g_first
            assign rem_prev  = EW'(sum_reg);
            assign root_prev = '0;
        end else begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
        end
        assign trial = (EW'(root_prev) << (RW - j)) + (EW'(1) << (2 * (RW - 1 - j)));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_prev >= trial) begin
                    rem_reg[j]  <= rem_prev - trial;
                    root_reg[j] <= root_prev | (RW'(1) << (RW - 1 - j));
                end else begin
                    rem_reg[j]  <= rem_prev;
                    root_reg[j] <= root_prev;
                end
            end
        end
    end

    if (LPAD > 0) begin : g_lpad
        logic [31:0] lpad_reg [LPAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                lpad_reg[0] <= len_reg;
                for (int k = 1; k < LPAD; k++) begin
                    lpad_reg[k] <= lpad_reg[k-1];
                end
            end
        end
        assign len_out = lpad_reg[LPAD-1];
    end else begin : g_lnopad
        assign len_out = len_reg;
    end
    assign m_length_mm = len_out;

    // heading by vectoring
    logic signed [31:0] vx_reg [N+1];
    logic signed [31:0] vy_reg [N+1];
    logic        [31:0] acc_reg [N+1];
    logic               vz_reg [N+1];
    logic               zero_in;

    assign zero_in = (in_item.dx == '0) && (in_item.dy == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            vz_reg[0] <= zero_in;
            if (in_item.dx[lsg_pkg::DELTA_W-1]) begin
                vx_reg[0]  <= -32'(in_item.dx);
                vy_reg[0]  <= -32'(in_item.dy);
                acc_reg[0] <= lsg_pkg::HALF_TURN;
            end else begin
                vx_reg[0]  <= 32'(in_item.dx);
                vy_reg[0]  <= 32'(in_item.dy);
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= N; j++) begin : g_vec
        logic signed [31:0] xs, ys;
        assign xs = vx_reg[j-1] >>> (j - 1);
        assign ys = vy_reg[j-1] >>> (j - 1);
        always_ff @(posedge aclk) begin
            if (en) begin
                vz_reg[j] <= vz_reg[j-1];
                if (vy_reg[j-1][31]) begin
                    vx_reg[j]  <= vx_reg[j-1] - ys;
                    vy_reg[j]  <= vy_reg[j-1] + xs;
                    acc_reg[j] <= acc_reg[j-1] - lsg_pkg::atan_q32(j - 1);
                end else begin
                    vx_reg[j]  <= vx_reg[j-1] + ys;
                    vy_reg[j]  <= vy_reg[j-1] - xs;
                    acc_reg[j] <= acc_reg[j-1] + lsg_pkg::atan_q32(j - 1);
                end
            end
        end
    end

    // fold heading into the right half plane for the rotation
    logic [31:0]          acc_rnd;
    logic [15:0]          head_c;
    logic signed [ZW-1:0] zs_c, zs_adj;
    logic                 flip_c;

    always_comb begin
        acc_rnd = acc_reg[N] + 32'h0000_8000;
        head_c  = vz_reg[N] ? 16'd0 : acc_rnd[31:16];
        zs_c    = ZW'($signed({head_c, 16'd0}));
        flip_c  = (zs_c > ZW'(34'sh4000_0000)) || (zs_c < -ZW'(34'sh4000_0000));
        if (!flip_c) begin
            zs_adj = zs_c;
        end else if (zs_c > 0) begin
            zs_adj = zs_c - ZW'(34'sh8000_0000);
        end else begin
            zs_adj = zs_c + ZW'(34'sh8000_0000);
        end
    end

    logic signed [ZW-1:0] rx_reg [N+1];
    logic signed [ZW-1:0] ry_reg [N+1];
    logic signed [ZW-1:0] rz_reg [N+1];
    logic        [15:0]   hd_reg [N+1];
    logic                 fl_reg [N+1];
    logic                 rzf_reg [N+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg[0]  <= lsg_pkg::GAIN_Q30;
            ry_reg[0]  <= '0;
            rz_reg[0]  <= zs_adj;
            hd_reg[0]  <= head_c;
            fl_reg[0]  <= flip_c;
            rzf_reg[0] <= vz_reg[N];
        end
    end

    for (genvar j = 1; j <= N; j++) begin : g_rot
        logic signed [ZW-1:0] xs, ys;
        assign xs = rx_reg[j-1] >>> (j - 1);
        assign ys = ry_reg[j-1] >>> (j - 1);
        always_ff @(posedge aclk) begin
            if (en) begin
                hd_reg[j]  <= hd_reg[j-1];
                fl_reg[j]  <= fl_reg[j-1];
                rzf_reg[j] <= rzf_reg[j-1];
                if (!rz_reg[j-1][ZW-1]) begin
                    rx_reg[j] <= rx_reg[j-1] - ys;
                    ry_reg[j] <= ry_reg[j-1] + xs;
                    rz_reg[j] <= rz_reg[j-1] - ZW'(lsg_pkg::atan_q32(j - 1));
                end else begin
                    rx_reg[j] <= rx_reg[j-1] + ys;
                    ry_reg[j] <= ry_reg[j-1] - xs;
                    rz_reg[j] <= rz_reg[j-1] + ZW'(lsg_pkg::atan_q32(j - 1));
                end
            end
        end
    end

    // round to Q1.14 and clamp
    logic signed [ZW-1:0] fx, fy;
    logic signed [ZW:0]   tx, ty;
    logic signed [18:0]   qx, qy;
    logic signed [15:0]   sin_c, cos_c;
    logic [47:0]          ang_reg;
    logic [47:0]          ang_out;

    always_comb begin
        fx = fl_reg[N] ? -rx_reg[N] : rx_reg[N];
        fy = fl_reg[N] ? -ry_reg[N] : ry_reg[N];
        tx = (ZW + 1)'(fx) + (ZW + 1)'(35'sd32768);
        ty = (ZW + 1)'(fy) + (ZW + 1)'(35'sd32768);
        qx = 19'(tx >>> 16);
        qy = 19'(ty >>> 16);
        if (qx > 19'sd16384) begin
            cos_c = lsg_pkg::Q14_ONE;
        end else if (qx < -19'sd16384) begin
            cos_c = -lsg_pkg::Q14_ONE;
        end else begin
            cos_c = 16'(qx);
        end
        if (qy > 19'sd16384) begin
            sin_c = lsg_pkg::Q14_ONE;
        end else if (qy < -19'sd16384) begin
            sin_c = -lsg_pkg::Q14_ONE;
        end else begin
            sin_c = 16'(qy);
        end
        if (rzf_reg[N]) begin
            sin_c = '0;
            cos_c = lsg_pkg::Q14_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= {hd_reg[N], sin_c, cos_c};
        end
    end

    if (APAD > 0) begin : g_apad
        logic [47:0] apad_reg [APAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                apad_reg[0] <= ang_reg;
                for (int k = 1; k < APAD; k++) begin
                    apad_reg[k] <= apad_reg[k-1];
                end
            end
        end
        assign ang_out = apad_reg[APAD-1];
    end else begin : g_anopad
        assign ang_out = ang_reg;
    end

    assign m_heading     = ang_out[47:32];
    assign m_heading_sin = ang_out[31:16];
    assign m_heading_cos = ang_out[15:0];

endmodule

// ===== rtl/line_segment_geometry_unit.sv =====
// Top level of the line segment geometry unit: register port, front, queue and back.
// Takes one segment transfer per clock while results are accepted on m_ready, and returns one
// result transfer per segment, in order. Each item passes through the front pipeline, queue
// and back pipeline, whose depth BACK_LAT is that of the longer of the square root path and
// the two CORDIC chains; the shorter path is padded to match.
// Both pipelines hold while their next stage is full; the four-entry queue between them absorbs
// short stalls. Offsets are written over the register port at 0x0 (offset_x) and 0x4 (offset_y).
module line_segment_geometry_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_start_east,
    input  logic signed [31:0] s_start_north,
    input  logic signed [31:0] s_end_east,
    input  logic signed [31:0] s_end_north,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_from_x_mm,
    output logic signed [31:0] m_from_y_mm,
    output logic signed [31:0] m_to_x_mm,
    output logic signed [31:0] m_to_y_mm,
    output logic        [31:0] m_length_mm,
    output logic signed [15:0] m_heading,
    output logic signed [15:0] m_heading_sin,
    output logic signed [15:0] m_heading_cos
);

    logic signed [31:0] offset_x_reg;
    logic signed [31:0] offset_y_reg;
    logic               reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == lsg_pkg::REG_OFFSET_X) ? offset_x_reg : offset_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (wr_en) begin
            if (reg_idx == lsg_pkg::REG_OFFSET_X) begin
                offset_x_reg <= pwdata;
            end else begin
                offset_y_reg <= pwdata;
            end
        end
    end

    logic          f_valid, f_ready;
    lsg_pkg::seg_t f_item;
    logic          q_valid, q_ready;
    lsg_pkg::seg_t q_item;

    lsg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_east  (s_start_east),
        .s_start_north (s_start_north),
        .s_end_east    (s_end_east),
        .s_end_north   (s_end_north),
        .offset_x      (offset_x_reg),
        .offset_y      (offset_y_reg),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_item      (f_item)
    );

    lsg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lsg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_from_x_mm   (m_from_x_mm),
        .m_from_y_mm   (m_from_y_mm),
        .m_to_x_mm     (m_to_x_mm),
        .m_to_y_mm     (m_to_y_mm),
        .m_length_mm   (m_length_mm),
        .m_heading     (m_heading),
        .m_heading_sin (m_heading_sin),
        .m_heading_cos (m_heading_cos)
    );

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_zero_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_length_mm == 32'd0 |->
            m_heading == 16'sd0 && m_heading_sin == 16'sd0 && m_heading_cos == lsg_pkg::Q14_ONE)
        else $error("zero-length segment with nonzero heading");

    a_equal_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_from_x_mm == m_to_x_mm && m_from_y_mm == m_to_y_mm |->
            m_length_mm == 32'd0)
        else $error("coincident ends with nonzero length");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for line_segment_geometry_unit: offsets, segment transfers, result checks.
module tb;

    typedef struct {
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] to_x;
        logic signed [31:0] to_y;
        logic [31:0]        len;
        logic [15:0]        head;
        logic [15:0]        sn;
        logic [15:0]        cs;
    } geom_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = lsg_pkg::FRONT_LAT + 1 + lsg_pkg::BACK_LAT + 20;

    localparam logic [31:0] ATAN_Q32 [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_start_east;
    logic signed [31:0] s_start_north;
    logic signed [31:0] s_end_east;
    logic signed [31:0] s_end_north;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_from_x_mm;
    logic signed [31:0] m_from_y_mm;
    logic signed [31:0] m_to_x_mm;
    logic signed [31:0] m_to_y_mm;
    logic        [31:0] m_length_mm;
    logic signed [15:0] m_heading;
    logic signed [15:0] m_heading_sin;
    logic signed [15:0] m_heading_cos;

    logic [31:0] offset_x;
    logic [31:0] offset_y;
    geom_t       pending_segments[$];
    int          fail_count;
    int          sent_count;
    int          checked_count;
    int          quiet_cycles;
    bit          idle_on;

    line_segment_geometry_unit uut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint to_mm(logic [31:0] coord, logic [31:0] off);
        longint v;
        longint q;
        v = (longint'($signed(coord)) - longint'($signed(off))) * 1000;
        if (v >= 0) begin
            q = (v + 32768) >>> 16;
        end else begin
            q = -((-v + 32768) >>> 16);
        end
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic logic [31:0] seg_length(longint dx, longint dy);
        bit [63:0] ax;
        bit [63:0] ay;
        bit [63:0] a2;
        bit [63:0] s;
        bit [63:0] r;
        bit [63:0] b;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        a2 = ax * ax;
        s  = a2 + ay * ay;
        if (s < a2) return 32'hFFFF_FFFF;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        s = ax * ax + ay * ay;
        if (s - r * r > r) r = r + 1;
        if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
        return r[31:0];
    endfunction

    function automatic logic [31:0] vector_angle(longint x, longint y);
        logic [31:0] acc;
        longint      xs;
        longint      ys;
        acc = 0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = lsg_pkg::HALF_TURN;
        end
        for (int i = 0; i < lsg_pkg::CS_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - ATAN_Q32[i];
            end else begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + ATAN_Q32[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] q14_round(longint v);
        longint q;
        q = (v + 32768) >>> 16;
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q[15:0];
    endfunction

    function automatic geom_t segment_geometry(logic [31:0] se, logic [31:0] sn,
                                               logic [31:0] ee, logic [31:0] en);
        geom_t       g;
        longint      fx, fy, tx, ty, dx, dy, zs, x, y, xs, ys;
        logic [31:0] acc;
        logic [31:0] z;
        bit          flip;
        fx = to_mm(sn, offset_x);
        fy = to_mm(se, offset_y);
        tx = to_mm(en, offset_x);
        ty = to_mm(ee, offset_y);
        dx = tx - fx;
        dy = ty - fy;
        g.from_x = fx[31:0];
        g.from_y = fy[31:0];
        g.to_x   = tx[31:0];
        g.to_y   = ty[31:0];
        g.len    = seg_length(dx, dy);
        g.head   = 16'd0;
        g.sn     = 16'd0;
        g.cs     = lsg_pkg::Q14_ONE;
        if (dx != 0 || dy != 0) begin
            acc    = vector_angle(dx, dy);
            acc    = acc + 32'h8000;
            g.head = acc[31:16];
            z      = {g.head, 16'h0000};
            zs     = longint'($signed(z));
            flip   = 1'b0;
            if (zs > 64'sh4000_0000 || zs < -64'sh4000_0000) begin
                zs   = (zs > 0) ? zs - 64'sh8000_0000 : zs + 64'sh8000_0000;
                flip = 1'b1;
            end
            x = lsg_pkg::GAIN_Q30;
            y = 0;
            for (int i = 0; i < lsg_pkg::CS_N; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (zs >= 0) begin
                    x  = x - ys;
                    y  = y + xs;
                    zs = zs - longint'(ATAN_Q32[i]);
                end else begin
                    x  = x + ys;
                    y  = y - xs;
                    zs = zs + longint'(ATAN_Q32[i]);
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            g.sn = q14_round(y);
            g.cs = q14_round(x);
        end
        return g;
    endfunction

    task automatic write_offset(logic addr_sel, logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {addr_sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== value) begin
            $error("readback addr %0d expected %h actual %h", paddr, value, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr_sel == lsg_pkg::REG_OFFSET_X) begin
            offset_x = value;
        end else begin
            offset_y = value;
        end
    endtask

    task automatic set_offsets(logic [31:0] ox, logic [31:0] oy);
        wait (pending_segments.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_offset(lsg_pkg::REG_OFFSET_X, ox);
        write_offset(lsg_pkg::REG_OFFSET_Y, oy);
    endtask

    // hold valid across back-to-back transfers; drop it only on a gap
    task automatic send_segment(logic [31:0] se, logic [31:0] sn,
                                logic [31:0] ee, logic [31:0] en);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_start_east  = se;
        s_start_north = sn;
        s_end_east    = ee;
        s_end_north   = en;
        do @(posedge aclk); while (!s_ready);
        pending_segments.push_back(segment_geometry(se, sn, ee, en));
        sent_count++;
    endtask

    task automatic end_stream();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic test_special_segments();
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        idle_on = 1'b0;
        send_segment(0, 0, 0, 0);
        send_segment(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
        send_segment(0, 32'h0005_0000, 0, 32'h0001_0000);
        send_segment(0, 0, 0, 32'h0001_0000);
        send_segment(0, 0, 32'h0001_0000, 0);
        send_segment(0, 0, 32'hFFFF_0000, 0);
        send_segment(0, 0, 32'h0003_0000, 32'h0003_0000);
        send_segment(0, 0, 32'hFFFD_0000, 32'h0003_0000);
        send_segment(0, 0, 32'hFFFD_0000, 32'hFFFD_0000);
        send_segment(0, 0, 32'h0003_0000, 32'hFFFD_0000);
        send_segment(mn, mn, mx, mx);
        send_segment(mx, mx, mn, mn);
        send_segment(mn, mx, mx, mn);
        send_segment(mx, mn, mn, mx);
        send_segment(0, 0, 32'h0000_0021, 0);
        send_segment(0, 0, 32'h0000_0020, 32'hFFFF_FFDF);
        send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        send_segment(0, 0, 32'h0000_0042, 32'h0000_0042);
        end_stream();
    endtask

    task automatic test_offset_extremes();
        set_offsets(32'h8000_0000, 32'h7FFF_FFFF);
        idle_on = 1'b1;
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(0, 0, 0, 0);
        end_stream();
        set_offsets(32'h7FFF_FFFF, 32'h8000_0000);
        send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        end_stream();
    endtask

    task automatic test_random_segments(int count);
        logic [31:0] se, sn, ee, en;
        int          span;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            se = $urandom;
            sn = $urandom;
            case ($urandom_range(0, 5))
                0: begin
                    ee = $urandom;
                    en = $urandom;
                end
                1: begin
                    ee = se;
                    en = sn;
                end
                2: begin
                    ee = se;
                    en = sn + $signed($urandom_range(0, 2000000)) - 1000000;
                end
                3: begin
                    en = sn;
                    ee = se + $signed($urandom_range(0, 2000000)) - 1000000;
                end
                default: begin
                    span = 1 << $urandom_range(0, 24);
                    ee = se + $signed($urandom_range(0, 2 * span)) - span;
                    en = sn + $signed($urandom_range(0, 2 * span)) - span;
                end
            endcase
            send_segment(se, sn, ee, en);
        end
        end_stream();
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 8) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_segments.size() == 0) begin
                $error("result transfer with no segment pending");
                fail_count++;
            end else begin
                geom_t g;
                g = pending_segments.pop_front();
                checked_count++;
                if (m_from_x_mm !== g.from_x) begin
                    $error("from_x_mm expected %0d actual %0d", g.from_x, m_from_x_mm);
                    fail_count++;
                end
                if (m_from_y_mm !== g.from_y) begin
                    $error("from_y_mm expected %0d actual %0d", g.from_y, m_from_y_mm);
                    fail_count++;
                end
                if (m_to_x_mm !== g.to_x) begin
                    $error("to_x_mm expected %0d actual %0d", g.to_x, m_to_x_mm);
                    fail_count++;
                end
                if (m_to_y_mm !== g.to_y) begin
                    $error("to_y_mm expected %0d actual %0d", g.to_y, m_to_y_mm);
                    fail_count++;
                end
                if (m_length_mm !== g.len) begin
                    $error("length_mm expected %0d actual %0d", g.len, m_length_mm);
                    fail_count++;
                end
                if (m_heading !== g.head) begin
                    $error("heading expected %0d actual %0d", $signed(g.head), m_heading);
                    fail_count++;
                end
                if (m_heading_sin !== g.sn) begin
                    $error("heading_sin expected %0d actual %0d", $signed(g.sn), m_heading_sin);
                    fail_count++;
                end
                if (m_heading_cos !== g.cs) begin
                    $error("heading_cos expected %0d actual %0d", $signed(g.cs), m_heading_cos);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_start_east  = '0;
        s_start_north = '0;
        s_end_east    = '0;
        s_end_north   = '0;
        offset_x      = '0;
        offset_y      = '0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        idle_on       = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_special_segments();
        test_offset_extremes();
        set_offsets(32'h0000_0000, 32'h0000_0000);
        test_random_segments(300);
        set_offsets(32'h8000_0000, 32'h8000_0000);
        test_random_segments(300);
        set_offsets(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        test_random_segments(300);
        set_offsets($urandom, $urandom);
        test_random_segments(300);

        wait (pending_segments.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d segments under 7 offset settings, %0d results checked.",
                 sent_count, checked_count);
        $display("Covered zero length, straight backward, axis headings and coordinate extremes.");
        if (fail_count == 0 && pending_segments.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lsg_pkg.sv
rtl/lsg_front.sv
rtl/lsg_queue.sv
rtl/lsg_back.sv
rtl/line_segment_geometry_unit.sv
test/tb.sv
